// ===== rtl/core/mvsm_pkg.sv =====
// Shared types and constants for the multi-voice sample mixer.
package mvsm_pkg;

  localparam int unsigned Voices      = 16;
  localparam int unsigned VoiceW      = $clog2(Voices);
  localparam int unsigned SampleWords = 65536;
  localparam int unsigned MemAddrW    = $clog2(SampleWords);

  localparam logic [15:0] PitchMin = 16'd410;
  localparam logic [15:0] PitchMax = 16'd40960;
  localparam logic [17:0] RateReset = 18'd44100;

  typedef enum logic [2:0] {
    ACT_WRITE = 3'd0,
    ACT_PLAY  = 3'd1,
    ACT_STOPV = 3'd2,
    ACT_STOPS = 3'd3,
    ACT_MIX   = 3'd4
  } action_e;

  // Divider request: dividend up to 38 bits, divisor 18 bits.
  typedef struct packed {
    logic        start;
    logic [37:0] num;
    logic [17:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [37:0] quo;
  } div_rsp_t;

  // Saturate a signed value to 16 bits.
  function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
    if (v > 36'sd32767) return 16'sh7fff;
    if (v < -36'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

endpackage

// ===== rtl/core/mvsm_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
module mvsm_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mvsm_pkg::div_req_t  req_i,
  output mvsm_pkg::div_rsp_t  rsp_o
);
  import mvsm_pkg::*;

  logic [37:0] quo_q, quo_d;
  logic [18:0] rem_q, rem_d;
  logic [17:0] den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [18:0] trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[17:0], quo_q[37]};
    if (req_i.start) begin
      quo_d  = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
      cnt_d  = 6'd38;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[36:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[36:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

// ===== rtl/core/multi_voice_sample_mixer.sv =====
// Top level of the multi-voice sample mixer.
//
// Input channel: in_valid_i / in_stall_o carry one action item (write sample
// word, play, stop voice, stop sample, mix frame). Output channel:
// out_valid_o / out_stall_i carry exactly one result item per input item.
// Configuration: cfg_we_i writes output_rate from cfg_wdata_i at any edge.
//
// Flow: one item at a time. Stop sample walks the voices, one voice per cycle;
// play passes over playing voices to the lowest free one (none when all are
// playing), then a 38-step bit-serial divider forms the voice step. Mix runs,
// per playing voice, a check, a memory read, a gain multiply, and left and
// right pan multiplies through one shared multiplier; a stopped or expired
// voice gets only the check. The input is stalled from acceptance until the
// item moves into the result register.
//
// Reset clears all voice state and sets output_rate to 44100; sample memory
// is not cleared. When the receiver stalls, the result holds in the output
// register; the next item is still taken and worked, and holds in its last
// state until the register frees.
module multi_voice_sample_mixer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [17:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          action_i,
  input  logic [15:0]         mem_addr_i,
  input  logic signed [15:0]  mem_data_i,
  input  logic [3:0]          voice_index_i,
  input  logic [15:0]         sample_start_i,
  input  logic [16:0]         sample_length_i,
  input  logic [17:0]         sample_rate_i,
  input  logic [15:0]         gain_i,
  input  logic [15:0]         pitch_i,
  input  logic signed [15:0]  pan_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [15:0]  left_o,
  output logic signed [15:0]  right_o,
  output logic                voice_found_o,
  output logic [3:0]          allocated_voice_o,
  output logic [4:0]          active_voices_o
);
  import mvsm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_FIND, S_DIV, S_STOPS, S_MIXCHK, S_MIXRD, S_MIXG,
    S_MIXL, S_MIXR, S_DONE
  } state_e;

  state_e state_q;
  logic [17:0] orate_q;

  // Voice state, one register per voice.
  logic [Voices-1:0]  play_q;
  logic [15:0]        vstart_q [Voices];
  logic [16:0]        vlen_q   [Voices];
  logic [31:0]        vpos_q   [Voices];
  logic [31:0]        vstep_q  [Voices];
  logic [15:0]        vgain_q  [Voices];
  logic signed [14:0] vpan_q   [Voices];

  logic signed [15:0] mem [SampleWords];
  logic signed [15:0] rd_q;

  // Captured item.
  logic [2:0]  act_q;
  logic [15:0] addr_q, start_q, gain_q;
  logic signed [15:0] data_q;
  logic [3:0]  vidx_q;
  logic [16:0] len_q;
  logic [37:0] prod_q;
  logic signed [14:0] pan_q;

  logic [VoiceW-1:0] idx_q;
  logic signed [15:0] s_q;
  logic signed [35:0] suml_q, sumr_q;
  logic               found_q;

  logic out_valid_q;
  logic signed [15:0] left_q, right_q;
  logic found_o_q;
  logic [3:0] alloc_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  mvsm_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  // Shared multiplier: 17-bit signed by 18-bit signed.
  logic signed [16:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [34:0] mul_p;
  assign mul_p = mul_a * mul_b;

  // Clamp pitch and halve/clamp pan for a play action.
  logic [15:0] pitch_c;
  logic signed [15:0] pan_h;
  logic signed [14:0] pan_c;
  always_comb begin
    pitch_c = pitch_i;
    if (pitch_i < PitchMin) pitch_c = PitchMin;
    if (pitch_i > PitchMax) pitch_c = PitchMax;
    pan_h = pan_i >>> 1;
    pan_c = pan_h[14:0];
    if (pan_h > 16'sd8192) pan_c = 15'sd8192;
    if (pan_h < -16'sd8192) pan_c = -15'sd8192;
  end

  logic [31:0] cur_pos;
  logic [32:0] np;
  logic [15:0] rd_addr;
  logic signed [35:0] pr_sh;
  assign cur_pos = vpos_q[idx_q];
  assign np      = {1'b0, cur_pos} + {1'b0, vstep_q[idx_q]};
  assign rd_addr = vstart_q[idx_q] + cur_pos[31:16];

  always_comb begin
    mul_a = 17'(s_q);
    mul_b = 18'sd0;
    unique case (state_q)
      S_MIXG: begin
        mul_a = 17'(rd_q);
        mul_b = $signed({2'b00, vgain_q[idx_q]});
      end
      S_MIXL: mul_b = 18'sd8192 - 18'(vpan_q[idx_q]);
      S_MIXR: mul_b = 18'sd8192 + 18'(vpan_q[idx_q]);
      default: ;
    endcase
    pr_sh = 36'(mul_p >>> 14);
  end

  logic [4:0] cnt;
  always_comb begin
    cnt = '0;
    for (int i = 0; i < Voices; i++) cnt = cnt + 5'(play_q[i]);
  end

  logic divisor_zero;
  assign divisor_zero = (orate_q == '0);
  assign div_req.start = (state_q == S_FIND) && !play_q[idx_q];
  assign div_req.num   = {prod_q[33:0], 4'b0000};
  assign div_req.den   = divisor_zero ? 18'd1 : orate_q;

  assign in_stall_o = (state_q != S_IDLE);

  // Move the finished item into the result register once it is free.
  logic res_load;
  assign res_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i && !in_stall_o) begin
      act_q   <= action_i;
      addr_q  <= mem_addr_i;
      data_q  <= mem_data_i;
      vidx_q  <= voice_index_i;
      start_q <= sample_start_i;
      len_q   <= sample_length_i;
      gain_q  <= gain_i;
      pan_q   <= pan_c;
      prod_q  <= 38'(sample_rate_i * pitch_c);
    end
    if (state_q == S_MIXRD) rd_q <= mem[rd_addr];
    if (state_q == S_DONE && act_q == ACT_WRITE) mem[addr_q] <= data_q;
    if (state_q == S_MIXG) s_q <= sat16(36'(mul_p >>> 12));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      orate_q     <= RateReset;
      play_q      <= '0;
      idx_q       <= '0;
      found_q     <= 1'b0;
      suml_q      <= '0;
      sumr_q      <= '0;
      out_valid_q <= 1'b0;
      left_q      <= '0;
      right_q     <= '0;
      found_o_q   <= 1'b0;
      alloc_q     <= '0;
      for (int i = 0; i < Voices; i++) begin
        vstart_q[i] <= '0;
        vlen_q[i]   <= '0;
        vpos_q[i]   <= '0;
        vstep_q[i]  <= '0;
        vgain_q[i]  <= '0;
        vpan_q[i]   <= '0;
      end
    end else begin
      if (cfg_we_i) orate_q <= cfg_wdata_i;
      if (res_load) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && !in_stall_o) begin
            idx_q   <= '0;
            found_q <= 1'b0;
            suml_q  <= '0;
            sumr_q  <= '0;
            // Stop voice: clear the voice right away so the count sees it.
            if (action_i == ACT_STOPV && {1'b0, voice_index_i} < 5'(Voices)) begin
              play_q[VoiceW'(voice_index_i)]   <= 1'b0;
              vstart_q[VoiceW'(voice_index_i)] <= '0;
              vlen_q[VoiceW'(voice_index_i)]   <= '0;
              vpos_q[VoiceW'(voice_index_i)]   <= '0;
              vstep_q[VoiceW'(voice_index_i)]  <= '0;
              vgain_q[VoiceW'(voice_index_i)]  <= '0;
              vpan_q[VoiceW'(voice_index_i)]   <= '0;
            end
            unique case (action_i)
              ACT_PLAY:  state_q <= S_FIND;
              ACT_STOPS: state_q <= S_STOPS;
              ACT_MIX:   state_q <= S_MIXCHK;
              default:   state_q <= S_DONE;
            endcase
          end
        end
        S_FIND: begin
          // Take the lowest stopped voice; divider started this cycle.
          if (!play_q[idx_q]) begin
            state_q <= S_DIV;
          end else if (idx_q == VoiceW'(Voices - 1)) begin
            state_q <= S_DONE;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            play_q[idx_q]   <= 1'b1;
            vstart_q[idx_q] <= start_q;
            vlen_q[idx_q]   <= len_q;
            vpos_q[idx_q]   <= '0;
            vstep_q[idx_q]  <= (div_rsp.quo[37:32] != '0) ? 32'hffff_ffff
                                                          : div_rsp.quo[31:0];
            vgain_q[idx_q]  <= gain_q;
            vpan_q[idx_q]   <= pan_q;
            found_q         <= 1'b1;
            state_q         <= S_DONE;
          end
        end
        S_STOPS: begin
          if (vstart_q[idx_q] == start_q) begin
            play_q[idx_q]   <= 1'b0;
            vstart_q[idx_q] <= '0;
            vlen_q[idx_q]   <= '0;
            vpos_q[idx_q]   <= '0;
            vstep_q[idx_q]  <= '0;
            vgain_q[idx_q]  <= '0;
            vpan_q[idx_q]   <= '0;
          end
          if (idx_q == VoiceW'(Voices - 1)) state_q <= S_DONE;
          else idx_q <= idx_q + 1'b1;
        end
        S_MIXCHK: begin
          // Skip stopped voices; drop voices that ran past their end.
          if (play_q[idx_q] && !(cur_pos == 32'hffff_ffff ||
              {1'b0, cur_pos[31:16]} >= vlen_q[idx_q])) begin
            state_q <= S_MIXRD;
          end else begin
            if (play_q[idx_q]) begin
              play_q[idx_q]   <= 1'b0;
              vstart_q[idx_q] <= '0;
              vlen_q[idx_q]   <= '0;
              vpos_q[idx_q]   <= '0;
              vstep_q[idx_q]  <= '0;
              vgain_q[idx_q]  <= '0;
              vpan_q[idx_q]   <= '0;
            end
            if (idx_q == VoiceW'(Voices - 1)) state_q <= S_DONE;
            else idx_q <= idx_q + 1'b1;
          end
        end
        S_MIXRD: state_q <= S_MIXG;
        S_MIXG:  state_q <= S_MIXL;
        S_MIXL: begin
          suml_q  <= suml_q + 36'(sat16(pr_sh));
          state_q <= S_MIXR;
        end
        S_MIXR: begin
          sumr_q <= sumr_q + 36'(sat16(pr_sh));
          vpos_q[idx_q] <= np[32] ? 32'hffff_ffff : np[31:0];
          if (idx_q == VoiceW'(Voices - 1)) state_q <= S_DONE;
          else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_MIXCHK;
          end
        end
        S_DONE: begin
          // Hold here while the previous result still waits downstream.
          if (res_load) begin
            left_q    <= (act_q == ACT_MIX) ? sat16(suml_q) : '0;
            right_q   <= (act_q == ACT_MIX) ? sat16(sumr_q) : '0;
            found_o_q <= found_q;
            alloc_q   <= found_q ? 4'(idx_q) : '0;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Count is taken as the result loads, after every voice update has landed.
  logic [4:0] active_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) active_q <= '0;
    else if (res_load) active_q <= cnt;
  end

  assign out_valid_o       = out_valid_q;
  assign left_o            = left_q;
  assign right_o           = right_q;
  assign voice_found_o     = found_o_q;
  assign allocated_voice_o = alloc_q;
  assign active_voices_o   = active_q;

endmodule
